### rtl/svr_pkg.sv
// Package for the secret value redactor: constants, key table, payload and control types.
`timescale 1ns / 1ps
package svr_pkg;

   localparam int HISTORY_BYTES = 8;
   localparam int KEY_COUNT     = 4;
   localparam int KEY_MAX       = 8;
   localparam int CSR_IDX_W     = 1;

   localparam logic [7:0] EQUALS_BYTE     = 8'd61;
   localparam logic [7:0] MASK_CHAR_RESET = 8'd42;
   localparam logic [7:0] VALUE_END_RESET = 8'd59;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASK_CHAR = 1'b0,
      CSR_VALUE_END = 1'b1
   } csr_index_type;

   typedef logic [KEY_MAX-1:0][7:0] key_text_type;

   // Keys stored first character at index 0
   localparam key_text_type KEY_TEXT [KEY_COUNT] = '{
      {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "D", "W", "P"},
      {"D", "R", "O", "W", "S", "S", "A", "P"},
      {8'd0, 8'd0, "T", "E", "R", "C", "E", "S"},
      {8'd0, 8'd0, 8'd0, "N", "E", "K", "O", "T"}
   };
   localparam int KEY_LEN [KEY_COUNT] = '{3, 8, 6, 5};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       was_masked;
   } rsp_type;

   // What one history cell compares against, per key
   typedef struct packed {
      logic [KEY_COUNT-1:0][7:0] chr;
      logic [KEY_COUNT-1:0]      care;
   } cell_pattern_type;

   // Control handed to the history chain
   typedef struct packed {
      logic       shift;
      logic       clear;
      logic [7:0] data;
   } chain_ctrl_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd97 && c <= 8'd122) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   // Slot 0 is the newest byte; it must match the last character of a key
   function automatic cell_pattern_type cell_pattern(input int slot);
      cell_pattern_type p;
      p = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (slot < KEY_LEN[k]) begin
            p.care[k] = 1'b1;
            p.chr[k]  = KEY_TEXT[k][KEY_LEN[k] - 1 - slot];
         end
      end
      return p;
   endfunction

endpackage

### rtl/svr_cell.sv
// One history cell: holds a byte, passes it on and compares it against its key characters.
`timescale 1ns / 1ps
module svr_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  svr_pkg::chain_ctrl_type    ctrl,
   input  logic [7:0]                 data_in,
   input  svr_pkg::cell_pattern_type  pattern,
   output logic [7:0]                 data_out,
   output logic [svr_pkg::KEY_COUNT-1:0] match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [7:0] folded;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = '0;
      end else if (ctrl.shift) begin
         byte_in = data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign folded   = svr_pkg::fold_upper(byte_ff);
   assign data_out = byte_ff;

   always_comb begin
      for (int k = 0; k < svr_pkg::KEY_COUNT; k++) begin
         match[k] = !pattern.care[k] || (folded == pattern.chr[k]);
      end
   end

endmodule

### rtl/svr_chain.sv
// Row of history cells and the key hit reduction over them.
`timescale 1ns / 1ps
module svr_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  svr_pkg::chain_ctrl_type ctrl,
   output logic                    key_hit
);

   localparam int N = svr_pkg::HISTORY_BYTES;
   localparam int K = svr_pkg::KEY_COUNT;

   logic [N-1:0][7:0] cell_byte;
   logic [N-1:0][K-1:0] cell_match;
   logic [K-1:0] key_full;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [7:0] link;
      if (i == 0) begin : g_head
         assign link = ctrl.data;
      end else begin : g_body
         assign link = cell_byte[i-1];
      end
      svr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .data_in  (link),
         .pattern  (svr_pkg::cell_pattern(i)),
         .data_out (cell_byte[i]),
         .match    (cell_match[i])
      );
   end

   // Drop keys longer than the history
   always_comb begin
      for (int k = 0; k < K; k++) begin
         key_full[k] = (svr_pkg::KEY_LEN[k] <= N);
         for (int i = 0; i < N; i++) begin
            key_full[k] = key_full[k] & cell_match[i][k];
         end
      end
   end

   assign key_hit = |key_full;

endmodule

### rtl/secret_value_redactor.sv
// Top level of the secret value redactor: handshakes, masking control, CSRs.
// The response is registered in the output register at the edge that accepts the request.
// One byte per cycle unless rsp_ready stalls; the chain key compare is combinational.
// Ready follows the output register: a new request is taken while the response drains.
// Reset (synchronous): history cleared, masking off, mask '*' and terminator ';'.
`timescale 1ns / 1ps
module secret_value_redactor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  svr_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output svr_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [svr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                           csr_data
);

   logic             masking_ff, masking_in;
   logic             rsp_valid_ff, rsp_valid_in;
   svr_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]       mask_char_ff, mask_char_in;
   logic [7:0]       value_end_ff, value_end_in;
   logic             req_fire;
   logic             key_hit;
   svr_pkg::chain_ctrl_type chain_ctrl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   svr_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (chain_ctrl),
      .key_hit (key_hit)
   );

   always_comb begin
      masking_in = masking_ff;
      rsp_in     = rsp_ff;
      rsp_in.out_byte   = req_data.in_byte;
      rsp_in.out_last   = req_data.in_last;
      rsp_in.was_masked = 1'b0;
      if (masking_ff) begin
         if (req_data.in_byte == value_end_ff) begin
            masking_in = 1'b0;
         end else begin
            rsp_in.out_byte   = mask_char_ff;
            rsp_in.was_masked = 1'b1;
         end
      end else if (req_data.in_byte == svr_pkg::EQUALS_BYTE && key_hit) begin
         masking_in = 1'b1;
      end
      if (req_data.in_last) begin
         masking_in = 1'b0;
      end
      if (!req_fire) begin
         masking_in = masking_ff;
         rsp_in     = rsp_ff;
      end
   end

   // History takes the emitted byte; end of line clears it
   always_comb begin
      chain_ctrl.shift = req_fire;
      chain_ctrl.clear = req_fire && req_data.in_last;
      chain_ctrl.data  = rsp_in.out_byte;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      mask_char_in = mask_char_ff;
      value_end_in = value_end_ff;
      if (csr_valid) begin
         unique case (svr_pkg::csr_index_type'(csr_index))
            svr_pkg::CSR_MASK_CHAR: mask_char_in = csr_data;
            svr_pkg::CSR_VALUE_END: value_end_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masking_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_char_ff <= svr_pkg::MASK_CHAR_RESET;
         value_end_ff <= svr_pkg::VALUE_END_RESET;
      end else begin
         masking_ff   <= masking_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_char_ff <= mask_char_in;
         value_end_ff <= value_end_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_clears_masking: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.in_last |=> !masking_ff)
      else $error("masking survived end of line");

   a_fire_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_value_byte_masked: assert property (@(posedge clock) disable iff (reset)
      req_fire && masking_ff && (req_data.in_byte != value_end_ff) |=> rsp_ff.was_masked)
      else $error("value byte passed unmasked");

   a_idle_not_masked: assert property (@(posedge clock) disable iff (reset)
      req_fire && !masking_ff |=> !rsp_ff.was_masked)
      else $error("byte masked outside a value");

endmodule

### tb/tb_top.sv
// Testbench for the secret value redactor: directed and random log lines against a predictor.
`timescale 1ns / 1ps
module tb_top;

   localparam int IDLE_PCT     = 31;
   localparam int QUIET_CYCLES = 4;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   svr_pkg::req_type              req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   svr_pkg::rsp_type              rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [svr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                    csr_data  = '0;

   secret_value_redactor DUT (.*);

   string            secret_keys [svr_pkg::KEY_COUNT] = '{"PWD", "PASSWORD", "SECRET", "TOKEN"};
   logic [7:0]       emitted_hist [svr_pkg::HISTORY_BYTES];
   logic             in_secret;
   logic [7:0]       mask_char_q;
   logic [7:0]       value_end_q;
   svr_pkg::rsp_type pending_redactions [$];
   int               fault_count   = 0;
   int               checked_count = 0;
   int               bytes_sent    = 0;
   bit               steady        = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [7:0] upper_of(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   // Newest history byte must match the final character of the key
   function automatic bit key_at_tail();
      string key;
      int    n;
      bit    hit;
      for (int k = 0; k < svr_pkg::KEY_COUNT; k++) begin
         key = secret_keys[k];
         n   = key.len();
         if (n > svr_pkg::HISTORY_BYTES) continue;
         hit = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (upper_of(emitted_hist[n - 1 - i]) != key[i]) hit = 1'b0;
         end
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void forget_line();
      for (int i = 0; i < svr_pkg::HISTORY_BYTES; i++) emitted_hist[i] = 8'h00;
      in_secret = 1'b0;
   endfunction

   function automatic svr_pkg::rsp_type redact_byte(input svr_pkg::req_type r);
      svr_pkg::rsp_type o;
      o.out_byte   = r.in_byte;
      o.out_last   = r.in_last;
      o.was_masked = 1'b0;
      if (in_secret) begin
         if (r.in_byte == value_end_q) begin
            in_secret = 1'b0;
         end else begin
            o.out_byte   = mask_char_q;
            o.was_masked = 1'b1;
         end
      end else if (r.in_byte == svr_pkg::EQUALS_BYTE && key_at_tail()) begin
         in_secret = 1'b1;
      end
      // history holds what went out, so masked bytes never form a key
      for (int i = svr_pkg::HISTORY_BYTES - 1; i > 0; i--) begin
         emitted_hist[i] = emitted_hist[i - 1];
      end
      emitted_hist[0] = o.out_byte;
      if (r.in_last) forget_line();
      return o;
   endfunction

   function automatic void report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      svr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_redactions.size() == 0) begin
            report_fault($sformatf("unexpected response: byte %02h last %b masked %b",
                                   rsp_data.out_byte, rsp_data.out_last, rsp_data.was_masked));
         end else begin
            want = pending_redactions.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.out_last !== want.out_last ||
                rsp_data.was_masked !== want.was_masked) begin
               report_fault($sformatf(
                  "response %0d: expected byte %02h last %b masked %b, got %02h %b %b",
                  checked_count, want.out_byte, want.out_last, want.was_masked,
                  rsp_data.out_byte, rsp_data.out_last, rsp_data.was_masked));
            end
         end
         checked_count++;
      end
      rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // Predict at acceptance; valid is left high for a following request
   task automatic send_byte(input logic [7:0] b, input logic last);
      svr_pkg::req_type r;
      r.in_byte = b;
      r.in_last = last;
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_redactions.push_back(redact_byte(r));
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && i == s.len() - 1);
   endtask

   // Hold off requests until every response is in
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_redactions.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input svr_pkg::csr_index_type idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         svr_pkg::CSR_MASK_CHAR: mask_char_q = val;
         svr_pkg::CSR_VALUE_END: value_end_q = val;
         default: ;
      endcase
   endtask

   // Mostly key=value pairs with random case and content, some broken pairs and noise
   task automatic send_line();
      logic [7:0] line [$];
      string      key;
      int         cut;
      repeat ($urandom_range(1, 3)) begin
         repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(8'h61, 8'h7A)));
         key = secret_keys[$urandom_range(0, svr_pkg::KEY_COUNT - 1)];
         case ($urandom_range(0, 9)) inside
            [0:6]: begin
               for (int i = 0; i < key.len(); i++) begin
                  line.push_back($urandom_range(0, 1) ? key[i] | 8'h20 : key[i]);
               end
               line.push_back(svr_pkg::EQUALS_BYTE);
               repeat ($urandom_range(0, 5)) begin
                  line.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h7A))
                                                      : 8'($urandom));
               end
               if ($urandom_range(0, 4) != 0) line.push_back(value_end_q);
            end
            7: begin
               // drop one character of the key so the equals sign follows a broken key
               cut = $urandom_range(0, key.len() - 1);
               for (int i = 0; i < key.len(); i++) begin
                  if (i != cut) line.push_back(key[i]);
               end
               line.push_back(svr_pkg::EQUALS_BYTE);
               repeat ($urandom_range(1, 3)) line.push_back(8'($urandom));
            end
            default: begin
               repeat ($urandom_range(1, 6)) line.push_back(8'($urandom));
            end
         endcase
      end
      foreach (line[i]) send_byte(line[i], i == line.size() - 1);
   endtask

   task automatic stream_lines(input int count);
      int goal;
      goal = bytes_sent + count;
      while (bytes_sent < goal) begin
         send_line();
         if (!steady && $urandom_range(0, 39) == 0) wait_for_quiet();
      end
   endtask

   task automatic test_default_settings();
      // mixed case key, empty value, second key on the same line, zero and all-ones bytes
      send_text("pWd=;Token=", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(svr_pkg::VALUE_END_RESET, 1'b1);
      // value runs to the end of the line
      send_text("SECRET=k", 1'b1);
   endtask

   task automatic test_equals_as_terminator();
      wait_for_quiet();
      write_csr(svr_pkg::CSR_MASK_CHAR, 8'h00);
      write_csr(svr_pkg::CSR_VALUE_END, svr_pkg::EQUALS_BYTE);
      send_text("PWD=a=b", 1'b1);
      stream_lines(40);
   endtask

   task automatic test_register_extremes();
      wait_for_quiet();
      write_csr(svr_pkg::CSR_MASK_CHAR, 8'hFF);
      write_csr(svr_pkg::CSR_VALUE_END, 8'h00);
      stream_lines(50);
      wait_for_quiet();
      write_csr(svr_pkg::CSR_MASK_CHAR, 8'h00);
      write_csr(svr_pkg::CSR_VALUE_END, 8'hFF);
      stream_lines(50);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         wait_for_quiet();
         write_csr(svr_pkg::CSR_MASK_CHAR, 8'($urandom));
         write_csr(svr_pkg::CSR_VALUE_END,
                   $urandom_range(0, 1) ? svr_pkg::VALUE_END_RESET : 8'($urandom));
         stream_lines(60);
      end
   endtask

   task automatic test_steady_stream();
      wait_for_quiet();
      write_csr(svr_pkg::CSR_MASK_CHAR, svr_pkg::MASK_CHAR_RESET);
      write_csr(svr_pkg::CSR_VALUE_END, svr_pkg::VALUE_END_RESET);
      steady = 1'b1;
      stream_lines(120);
      steady = 1'b0;
   endtask

   initial begin
      forget_line();
      mask_char_q = svr_pkg::MASK_CHAR_RESET;
      value_end_q = svr_pkg::VALUE_END_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_equals_as_terminator();
      test_register_extremes();
      test_random_settings();
      test_steady_stream();

      req_valid <= 1'b0;
      for (int n = 0; n < 1000 && pending_redactions.size() != 0; n++) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (pending_redactions.size() != 0) begin
         report_fault($sformatf("%0d responses never arrived", pending_redactions.size()));
      end
      if (fault_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

### secret_value_redactor.f
rtl/svr_pkg.sv
rtl/svr_cell.sv
rtl/svr_chain.sv
rtl/secret_value_redactor.sv
tb/tb_top.sv
